### sv/trr_pkg.sv
// ----------------------------------------------------------------------------
// trr_pkg
// Shared types and constants of the tape record reader controller: function
// codes, status codes, request and result kinds, parser control and events.
// ----------------------------------------------------------------------------
package trr_pkg;

	// function codes, compared after masking off the unit number
	localparam logic [11:0] FC_MASK          = 12'o7770;
	localparam logic [11:0] FC_SELECT        = 12'o2000;
	localparam logic [11:0] FC_WRITE_BIN     = 12'o2010;
	localparam logic [11:0] FC_READ_BIN      = 12'o2020;
	localparam logic [11:0] FC_BACKSPACE     = 12'o2030;
	localparam logic [11:0] FC_REWIND        = 12'o2060;
	localparam logic [11:0] FC_REWIND_UNLOAD = 12'o2070;
	localparam logic [11:0] FC_STATUS        = 12'o2100;
	localparam logic [11:0] FC_WRITE_BCD     = 12'o2210;
	localparam logic [11:0] FC_READ_BCD      = 12'o2220;
	localparam logic [11:0] FC_FILE_MARK     = 12'o2610;

	// drive status codes
	localparam logic [3:0] ST_READY       = 4'o00;
	localparam logic [3:0] ST_NOT_READY   = 4'o01;
	localparam logic [3:0] ST_END_OF_TAPE = 4'o10;

	// one buffer entry holds the two 12-bit words of a 3-byte group
	localparam int WORD_W = 12;
	localparam int PAIR_W = 2 * WORD_W;

	typedef enum logic [1:0] {
		REQ_FUNC        = 2'd0,
		REQ_CHAN_READ   = 2'd1,
		REQ_MEDIUM_BYTE = 2'd2,
		REQ_MEDIUM_END  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		RES_FUNC_REPLY = 2'd0,
		RES_CHAN_WORD  = 2'd1,
		RES_CHAN_DEACT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_REWIND  = 2'd1,
		CMD_DELIVER = 2'd2
	} mcmd_t;

	typedef enum logic [1:0] {
		PEND_NONE   = 2'd0,
		PEND_STATUS = 2'd1,
		PEND_READ   = 2'd2
	} pend_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_HEADER  = 4'b0010,
		PH_DATA    = 4'b0100,
		PH_TRAILER = 4'b1000
	} phase_t;

	// controller to parser
	typedef struct packed {
		logic start;
		logic abort;
		logic byte_en;
		logic end_en;
	} parse_ctl_t;

	// parser to controller, valid in the cycle of the causing item
	typedef struct packed {
		logic       done;
		logic       fail;
		logic [3:0] status;
	} parse_ev_t;

endpackage

### sv/trr_in_if.sv
// ----------------------------------------------------------------------------
// trr_in_if
// Request channel: function codes, channel reads and medium bytes.
// ----------------------------------------------------------------------------
interface trr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [11:0] func_code;
	logic [7:0]  medium_byte;

	modport source (output valid, req_type, func_code, medium_byte, input ready);
	modport sink (input valid, req_type, func_code, medium_byte, output ready);
endinterface

### sv/trr_out_if.sv
// ----------------------------------------------------------------------------
// trr_out_if
// Result channel: function replies, channel words and deactivations.
// ----------------------------------------------------------------------------
interface trr_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic        accepted;
	logic [11:0] channel_word;
	logic [1:0]  medium_cmd;
	logic [2:0]  unit_out;

	modport source (output valid, result_kind, accepted, channel_word, medium_cmd,
		unit_out, input ready);
	modport sink (input valid, result_kind, accepted, channel_word, medium_cmd,
		unit_out, output ready);
endinterface

### sv/trr_ram.sv
// ----------------------------------------------------------------------------
// trr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module trr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### sv/trr_parser.sv
// ----------------------------------------------------------------------------
// trr_parser
// Record frame parser: length header, data bytes packed two words per three
// bytes into the word buffer, and the length trailer check.
// ----------------------------------------------------------------------------
module trr_parser #(
	parameter int MAX_RECORD_BYTES = 6144,
	parameter int BUFFER_WORDS     = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  trr_pkg::parse_ctl_t                   ctl,
	input  logic [7:0]                            byte_data,
	output trr_pkg::parse_ev_t                    ev,
	output logic [$clog2(BUFFER_WORDS + 1)-1:0]   n_words,
	output logic                                  wr_en,
	output logic [(((BUFFER_WORDS + 1) / 2 > 1) ?
		$clog2((BUFFER_WORDS + 1) / 2) : 1)-1:0]   wr_addr,
	output logic [trr_pkg::PAIR_W-1:0]            wr_data
);
	import trr_pkg::*;

	localparam int WLW   = $clog2(BUFFER_WORDS + 1);
	localparam int PAIRS = (BUFFER_WORDS + 1) / 2;
	localparam int PAW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam int CW    = $clog2(MAX_RECORD_BYTES + 1);
	localparam int GW    = $clog2(MAX_RECORD_BYTES / 3 + 1);
	localparam int NW    = (GW + 2 > WLW) ? GW + 2 : WLW;

	phase_t          phase_q, phase_d;
	logic [CW-1:0]   cnt_q, cnt_d, cnt_inc;
	logic [31:0]     hdr_q, hdr_d, hdr_full;
	logic [31:0]     trl_q, trl_d, trl_full;
	logic [1:0]      pos_q, pos_d;
	logic [GW-1:0]   grp_q, grp_d;
	logic [7:0]      b0_q, b0_d, b1_q, b1_d;
	logic [WLW-1:0]  nw_q, nw_d;
	logic [NW-1:0]   n_raw;
	logic            last;
	logic            grp_in_range;

	// partial header and trailer with the current byte in its lane
	always_comb begin
		hdr_full = hdr_q;
		hdr_full[{cnt_q[1:0], 3'b000} +: 8] = byte_data;
		trl_full = trl_q;
		trl_full[{cnt_q[1:0], 3'b000} +: 8] = byte_data;
	end

	assign cnt_inc      = cnt_q + 1'b1;
	assign last         = cnt_inc >= hdr_q[CW-1:0];
	assign grp_in_range = 32'(grp_q) < 32'(PAIRS);
	assign n_raw        = NW'({grp_q, 1'b0}) + NW'(2);
	assign wr_addr      = PAW'(grp_q);
	assign n_words      = nw_q;

	// next state of the frame parse
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		hdr_d     = hdr_q;
		trl_d     = trl_q;
		pos_d     = pos_q;
		grp_d     = grp_q;
		b0_d      = b0_q;
		b1_d      = b1_q;
		nw_d      = nw_q;
		ev        = '0;
		wr_en     = 1'b0;
		wr_data   = '0;
		if (ctl.start) begin
			phase_d = PH_HEADER;
			cnt_d   = '0;
			hdr_d   = '0;
			trl_d   = '0;
			b0_d    = '0;
			b1_d    = '0;
		end else if (ctl.abort) begin
			phase_d = PH_IDLE;
		end else if (ctl.end_en) begin
			case (phase_q)
				PH_HEADER: begin
					ev.fail   = 1'b1;
					ev.status = ST_END_OF_TAPE;
					phase_d   = PH_IDLE;
				end
				PH_DATA, PH_TRAILER: begin
					ev.fail   = 1'b1;
					ev.status = ST_NOT_READY;
					phase_d   = PH_IDLE;
				end
				default: ;
			endcase
		end else if (ctl.byte_en) begin
			case (phase_q)
				PH_HEADER: begin
					hdr_d = hdr_full;
					cnt_d = cnt_inc;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_d = '0;
						pos_d = '0;
						grp_d = '0;
						if (hdr_full == 32'd0) begin
							// tape mark
							phase_d = PH_IDLE;
						end else if (hdr_full > 32'(MAX_RECORD_BYTES)) begin
							ev.fail   = 1'b1;
							ev.status = ST_NOT_READY;
							phase_d   = PH_IDLE;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					// pack the group; a short last group is padded with zero
					case (pos_q)
						2'd0: begin
							b0_d    = byte_data;
							wr_data = {12'h000, byte_data, 4'h0};
						end
						2'd1: begin
							b1_d    = byte_data;
							wr_data = {byte_data[3:0], 8'h00, b0_q, byte_data[7:4]};
						end
						default: begin
							wr_data = {b1_q[3:0], byte_data, b0_q, b1_q[7:4]};
						end
					endcase
					wr_en = (pos_q == 2'd2 || last) && grp_in_range;
					if (pos_q == 2'd2) begin
						pos_d = '0;
						grp_d = grp_q + 1'b1;
					end else begin
						pos_d = pos_q + 1'b1;
					end
					cnt_d = cnt_inc;
					if (last) begin
						phase_d = PH_TRAILER;
						cnt_d   = '0;
						trl_d   = '0;
						nw_d    = (n_raw > NW'(BUFFER_WORDS)) ? WLW'(BUFFER_WORDS)
							: WLW'(n_raw);
					end
				end
				PH_TRAILER: begin
					trl_d = trl_full;
					cnt_d = cnt_inc;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_d   = '0;
						phase_d = PH_IDLE;
						if (trl_full == hdr_q) begin
							ev.done = 1'b1;
						end else begin
							ev.fail   = 1'b1;
							ev.status = ST_NOT_READY;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			hdr_q   <= '0;
			trl_q   <= '0;
			pos_q   <= '0;
			grp_q   <= '0;
			b0_q    <= '0;
			b1_q    <= '0;
			nw_q    <= '0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			hdr_q   <= hdr_d;
			trl_q   <= trl_d;
			pos_q   <= pos_d;
			grp_q   <= grp_d;
			b0_q    <= b0_d;
			b1_q    <= b1_d;
			nw_q    <= nw_d;
		end
	end

	// buffer is written only while data bytes arrive
	a_wr_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> phase_q == PH_DATA)
		else $error("buffer write outside data phase");

	// a record in the data phase has a legal nonzero length
	a_len_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> (hdr_q != 32'd0 && hdr_q <= 32'(MAX_RECORD_BYTES)))
		else $error("data phase with illegal record length");

	// a finished record always reports a word count within the buffer
	a_done_count: assert property (@(posedge clk) disable iff (!arst_n)
		ev.done |-> (nw_q != '0 && 32'(nw_q) <= BUFFER_WORDS))
		else $error("record done with bad word count");
endmodule

### sv/tape_record_reader_controller.sv
// ----------------------------------------------------------------------------
// tape_record_reader_controller
// Tape controller: function decode, record parse into the word buffer and
// channel reads of status or buffered words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per item: a function code, a channel read, a
//   medium byte or a medium end. out_ch carries at most one result per item:
//   a function reply, a channel word or a channel deactivation. Medium items
//   and channel reads with nothing pending give no result.
//   Each item with a result is registered in the decode stage together with
//   any buffer read, and the result then passes the output register to out_ch.
//   One item is accepted every cycle while out_ch does not stall; this rate
//   is set by the read-modify of the controller state and the registered
//   read of the word buffer RAM, which holds three bytes of a record per entry.
//   Buffer writes happen only during a parse, while no words are left, and
//   reads only while words are left, so the two ports never touch one entry
//   in overlapping cycles.
//   Reset (arst_n low) clears unit, status, counters and the parse; the word
//   buffer is not cleared and needs no clearing pass. When out_ch stalls, the
//   output register and the decode stage hold one result each, after which
//   in_ch.ready drops until the output drains.
// ----------------------------------------------------------------------------
module tape_record_reader_controller #(
	parameter int MAX_RECORD_BYTES = 6144,
	parameter int BUFFER_WORDS     = 4096
) (
	input logic         clk,
	input logic         arst_n,
	trr_in_if.sink      in_ch,
	trr_out_if.source   out_ch
);
	import trr_pkg::*;

	localparam int RPW   = $clog2(BUFFER_WORDS);
	localparam int WLW   = $clog2(BUFFER_WORDS + 1);
	localparam int PAIRS = (BUFFER_WORDS + 1) / 2;
	localparam int PAW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;

	// controller state
	logic [2:0]      unit_q, unit_d;
	pend_t           pend_q, pend_d;
	logic [3:0]      status_q, status_dec, status_d;
	logic [WLW-1:0]  wl_q, wl_dec, wl_d;
	logic [RPW-1:0]  rp_q, rp_d;

	// decode results
	logic            accept;
	logic [11:0]     masked;
	logic            res_v;
	kind_t           kind;
	logic            acc;
	logic [11:0]     word;
	mcmd_t           cmd;
	logic            use_ram;
	logic            ram_re;
	parse_ctl_t      ctl;

	// parser and buffer
	parse_ev_t       ev;
	logic [WLW-1:0]  n_words;
	logic            wr_en;
	logic [PAW-1:0]  wr_addr;
	logic [PAIR_W-1:0] wr_data;
	logic [PAIR_W-1:0] rdata;

	// decode stage and output register
	logic            v_s1;
	kind_t           kind_s1;
	logic            acc_s1;
	logic [11:0]     word_s1;
	mcmd_t           cmd_s1;
	logic [2:0]      unit_s1;
	logic            ram_s1;
	logic            half_s1;
	logic            s1_move;
	logic            out_v_q;
	kind_t           out_kind_q;
	logic            out_acc_q;
	logic [11:0]     out_word_q;
	mcmd_t           out_cmd_q;
	logic [2:0]      out_unit_q;

	// handshake
	assign s1_move     = v_s1 && (!out_v_q || out_ch.ready);
	assign in_ch.ready = !v_s1 || s1_move;
	assign accept      = in_ch.valid && in_ch.ready;
	assign masked      = in_ch.func_code & FC_MASK;

	// request decode
	always_comb begin
		unit_d     = unit_q;
		pend_d     = pend_q;
		status_dec = status_q;
		wl_dec     = wl_q;
		rp_d       = rp_q;
		res_v      = 1'b0;
		kind       = RES_FUNC_REPLY;
		acc        = 1'b0;
		word       = '0;
		cmd        = CMD_NONE;
		use_ram    = 1'b0;
		ram_re     = 1'b0;
		ctl        = '0;
		if (accept) begin
			case (in_ch.req_type)
				REQ_FUNC: begin
					res_v = 1'b1;
					acc   = 1'b1;
					case (masked) inside
						FC_WRITE_BIN, FC_BACKSPACE, FC_REWIND_UNLOAD,
						FC_WRITE_BCD, FC_READ_BCD, FC_FILE_MARK: begin
							pend_d = PEND_NONE;
						end
						FC_REWIND: begin
							pend_d    = PEND_NONE;
							ctl.abort = 1'b1;
							cmd       = CMD_REWIND;
						end
						FC_STATUS: begin
							pend_d = PEND_STATUS;
						end
						FC_SELECT: begin
							pend_d = PEND_NONE;
							unit_d = in_ch.func_code[2:0];
						end
						FC_READ_BIN: begin
							pend_d     = PEND_READ;
							status_dec = ST_READY;
							if (wl_q == '0) begin
								rp_d      = '0;
								ctl.start = 1'b1;
								cmd       = CMD_DELIVER;
							end
						end
						default: begin
							acc = 1'b0;
						end
					endcase
				end
				REQ_CHAN_READ: begin
					case (pend_q)
						PEND_STATUS: begin
							res_v = 1'b1;
							kind  = RES_CHAN_WORD;
							word  = {8'h00, status_q};
						end
						PEND_READ: begin
							res_v = 1'b1;
							if (wl_q == '0) begin
								kind = RES_CHAN_DEACT;
							end else begin
								kind    = RES_CHAN_WORD;
								use_ram = 1'b1;
								ram_re  = 1'b1;
								rp_d    = rp_q + 1'b1;
								wl_dec  = wl_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
				REQ_MEDIUM_BYTE: begin
					ctl.byte_en = 1'b1;
				end
				default: begin
					ctl.end_en = 1'b1;
				end
			endcase
		end
	end

	// parser outcome on status and word count
	always_comb begin
		status_d = status_dec;
		wl_d     = wl_dec;
		if (ev.fail) begin
			status_d = ev.status;
			wl_d     = '0;
		end else if (ev.done) begin
			status_d = ST_READY;
			wl_d     = n_words;
		end
	end

	trr_parser #(
		.MAX_RECORD_BYTES (MAX_RECORD_BYTES),
		.BUFFER_WORDS     (BUFFER_WORDS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.byte_data (in_ch.medium_byte),
		.ev        (ev),
		.n_words   (n_words),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	trr_ram #(
		.WIDTH (PAIR_W),
		.DEPTH (PAIRS)
	) u_buffer (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (ram_re),
		.raddr (PAW'(rp_q >> 1)),
		.rdata (rdata)
	);

	// controller state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q   <= '0;
			pend_q   <= PEND_NONE;
			status_q <= ST_READY;
			wl_q     <= '0;
			rp_q     <= '0;
		end else begin
			unit_q   <= unit_d;
			pend_q   <= pend_d;
			status_q <= status_d;
			wl_q     <= wl_d;
			rp_q     <= rp_d;
		end
	end

	// decode stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= res_v;
		end else if (s1_move) begin
			v_s1 <= 1'b0;
		end
	end

	// decode stage payload, buffer data arrives alongside
	always_ff @(posedge clk) begin
		if (accept && res_v) begin
			kind_s1 <= kind;
			acc_s1  <= acc;
			word_s1 <= word;
			cmd_s1  <= cmd;
			unit_s1 <= unit_d;
			ram_s1  <= use_ram;
			half_s1 <= rp_q[0];
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_move) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// output register payload, selecting the word half of a buffer entry
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_kind_q <= kind_s1;
			out_acc_q  <= acc_s1;
			out_cmd_q  <= cmd_s1;
			out_unit_q <= unit_s1;
			if (ram_s1) begin
				out_word_q <= half_s1 ? rdata[PAIR_W-1:WORD_W] : rdata[WORD_W-1:0];
			end else begin
				out_word_q <= word_s1;
			end
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.result_kind  = out_kind_q;
	assign out_ch.accepted     = out_acc_q;
	assign out_ch.channel_word = out_word_q;
	assign out_ch.medium_cmd   = out_cmd_q;
	assign out_ch.unit_out     = out_unit_q;

	// word count never exceeds the buffer
	a_wl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wl_q) <= BUFFER_WORDS)
		else $error("words left beyond buffer size");

	// read pointer and remaining words stay within the buffer
	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rp_q) + 32'(wl_q) <= BUFFER_WORDS)
		else $error("read pointer runs past buffered words");

	// a channel read with a pending function always yields a result
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_ch.req_type == REQ_CHAN_READ && pend_q != PEND_NONE) |=> v_s1)
		else $error("channel read lost its result");
endmodule

### bench/tb_tape_record_reader_controller.sv
// ----------------------------------------------------------------------------
// tb_tape_record_reader_controller
// Self-checking bench for the tape record reader controller. A scoreboard
// class mirrors the function decode, the tape frame parse and the word buffer,
// and predicts every reply, channel word and deactivation. Each predicted
// item is compared field by field with what the block hands out. Stimulus is a
// short directed run, a longer record read out in full, then random record
// reads with flawed frames and noise under several sender and receiver idling
// mixes.
// ----------------------------------------------------------------------------
import trr_pkg::*;

typedef struct {
	kind_t       kind;
	logic        acc;
	logic [11:0] word;
	mcmd_t       cmd;
	logic [2:0]  unit;
} tape_result_t;

class tape_scoreboard #(int MAX_BYTES = 6144, int BUF_WORDS = 4096);
	// mirrored controller state
	logic [2:0]  unit;
	pend_t       pend;
	logic [3:0]  status;
	int unsigned left;
	int unsigned rd_ptr;
	logic [11:0] words [BUF_WORDS];
	phase_t      phase;
	bit [31:0]   hdr_len;
	bit [31:0]   trl_val;
	int unsigned nbytes;
	bit [7:0]    held;

	tape_result_t replies_due[$];
	int unsigned  errors;
	int unsigned  n_checked;
	int unsigned  n_records;

	function new();
		unit = 0;
		pend = PEND_NONE;
		status = ST_READY;
		left = 0;
		rd_ptr = 0;
		phase = PH_IDLE;
		hdr_len = 0;
		trl_val = 0;
		nbytes = 0;
		held = 0;
		foreach (words[i]) words[i] = 12'h000;
		errors = 0;
		n_checked = 0;
		n_records = 0;
	endfunction

	// words past the end of the buffer are dropped
	function void store_word(int unsigned idx, logic [11:0] w);
		if (idx < BUF_WORDS) words[idx] = w;
	endfunction

	function void abort_parse(logic [3:0] st);
		status = st;
		left = 0;
		phase = PH_IDLE;
	endfunction

	// flush a partial group, missing bytes read as zero
	function void close_data();
		int unsigned rem;
		int unsigned base;
		rem = hdr_len % 3;
		base = 2 * (hdr_len / 3);
		if (rem == 1) begin
			store_word(base, {held, 4'h0});
			store_word(base + 1, 12'h000);
		end else if (rem == 2) begin
			store_word(base + 1, {held[3:0], 8'h00});
		end
		phase = PH_TRAILER;
		nbytes = 0;
		trl_val = 0;
	endfunction

	// one tape byte through the frame parser
	function void take_byte(bit [7:0] b);
		int unsigned pos;
		int unsigned grp;
		int unsigned n;
		case (phase)
			PH_HEADER: begin
				hdr_len |= 32'(b) << (8 * (nbytes & 3));
				nbytes++;
				if (nbytes >= 4) begin
					nbytes = 0;
					if (hdr_len == 0) begin
						left = 0;
						phase = PH_IDLE;
					end else if (hdr_len > MAX_BYTES) begin
						abort_parse(ST_NOT_READY);
					end else begin
						phase = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				pos = nbytes % 3;
				grp = nbytes / 3;
				if (pos == 1)
					store_word(2 * grp, {held, b[7:4]});
				else if (pos == 2)
					store_word(2 * grp + 1, {held[3:0], b});
				held = b;
				nbytes++;
				if (nbytes >= hdr_len) close_data();
			end
			PH_TRAILER: begin
				trl_val |= 32'(b) << (8 * (nbytes & 3));
				nbytes++;
				if (nbytes >= 4) begin
					nbytes = 0;
					if (trl_val == hdr_len) begin
						n = 2 * ((hdr_len + 2) / 3);
						if (n > BUF_WORDS) n = BUF_WORDS;
						left = n;
						rd_ptr = 0;
						status = ST_READY;
						phase = PH_IDLE;
						n_records++;
					end else begin
						abort_parse(ST_NOT_READY);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// apply one accepted request; returns 0 for medium items the idle parser drops
	function bit note_input(req_t r, logic [11:0] fc, logic [7:0] mb);
		tape_result_t res;
		bit gives;
		res.kind = RES_FUNC_REPLY;
		res.acc = 1'b0;
		res.word = 12'h000;
		res.cmd = CMD_NONE;
		res.unit = 3'd0;
		gives = 1'b0;
		case (r)
			REQ_MEDIUM_BYTE: begin
				if (phase == PH_IDLE) return 1'b0;
				take_byte(mb);
			end
			REQ_MEDIUM_END: begin
				if (phase == PH_IDLE) return 1'b0;
				if (phase == PH_HEADER)
					abort_parse(ST_END_OF_TAPE);
				else
					abort_parse(ST_NOT_READY);
			end
			REQ_FUNC: begin
				gives = 1'b1;
				res.acc = 1'b1;
				case (fc & FC_MASK)
					FC_WRITE_BIN, FC_BACKSPACE, FC_REWIND_UNLOAD,
					FC_WRITE_BCD, FC_READ_BCD, FC_FILE_MARK: begin
						pend = PEND_NONE;
					end
					FC_REWIND: begin
						pend = PEND_NONE;
						phase = PH_IDLE;
						res.cmd = CMD_REWIND;
					end
					FC_STATUS: begin
						pend = PEND_STATUS;
					end
					FC_SELECT: begin
						pend = PEND_NONE;
						unit = fc[2:0];
					end
					FC_READ_BIN: begin
						pend = PEND_READ;
						status = ST_READY;
						if (left == 0) begin
							rd_ptr = 0;
							phase = PH_HEADER;
							hdr_len = 0;
							trl_val = 0;
							nbytes = 0;
							held = 0;
							res.cmd = CMD_DELIVER;
						end
					end
					default: res.acc = 1'b0;
				endcase
			end
			default: begin
				if (pend == PEND_STATUS) begin
					gives = 1'b1;
					res.kind = RES_CHAN_WORD;
					res.word = 12'(status);
				end else if (pend == PEND_READ) begin
					gives = 1'b1;
					if (left == 0) begin
						res.kind = RES_CHAN_DEACT;
					end else begin
						res.kind = RES_CHAN_WORD;
						res.word = words[rd_ptr % BUF_WORDS];
						rd_ptr = (rd_ptr + 1) & 12'hfff;
						left--;
					end
				end
			end
		endcase
		if (gives) begin
			res.unit = unit;
			replies_due.push_back(res);
		end
		return 1'b1;
	endfunction

	function void field_ok(string name, logic [11:0] exp, logic [11:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, actual %0d", name, exp, act);
			errors++;
		end
	endfunction

	// compare one delivered item with the oldest prediction
	function void check_result(logic [1:0] kind, logic acc, logic [11:0] word,
		logic [1:0] cmd, logic [2:0] unit_out);
		tape_result_t exp;
		if (replies_due.size() == 0) begin
			$error("result_kind %0d word %0d delivered with nothing expected", kind, word);
			errors++;
			return;
		end
		exp = replies_due.pop_front();
		n_checked++;
		field_ok("result_kind", 12'(exp.kind), 12'(kind));
		field_ok("accepted", 12'(exp.acc), 12'(acc));
		field_ok("channel_word", exp.word, word);
		field_ok("medium_cmd", 12'(exp.cmd), 12'(cmd));
		field_ok("unit_out", 12'(exp.unit), 12'(unit_out));
	endfunction
endclass

module tb_tape_record_reader_controller;

	localparam int MAX_REC_BYTES = 6144;
	localparam int BUF_DEPTH     = 4096;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 450;
	localparam int LONG_REC      = 98;

	typedef enum int {
		FLAW_NONE,
		FLAW_TRAILER,
		FLAW_END_HEADER,
		FLAW_END_DATA,
		FLAW_END_TRAILER,
		FLAW_DISTURB
	} flaw_t;

	logic clk = 1'b0;
	logic arst_n;

	trr_in_if  in_ch ();
	trr_out_if out_ch ();

	tape_record_reader_controller #(
		.MAX_RECORD_BYTES(MAX_REC_BYTES),
		.BUFFER_WORDS(BUF_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	tape_scoreboard #(.MAX_BYTES(MAX_REC_BYTES), .BUF_WORDS(BUF_DEPTH)) sb;

	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	bit          rx_hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned n_effective = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls plus a long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.result_kind, out_ch.accepted, out_ch.channel_word,
				out_ch.medium_cmd, out_ch.unit_out);
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tape_record_reader_controller: mismatch");
		$finish;
	end

	// offer one item, called and returning at a falling edge
	task automatic send_item(req_t r, logic [11:0] fc, logic [7:0] mb);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.req_type = r;
		in_ch.func_code = fc;
		in_ch.medium_byte = mb;
		do @(posedge clk); while (!in_ch.ready);
		if (sb.note_input(r, fc, mb)) n_effective++;
		@(negedge clk);
	endtask

	task automatic send_func(logic [11:0] code);
		send_item(REQ_FUNC, code, 8'($urandom));
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(REQ_MEDIUM_BYTE, 12'($urandom), b);
	endtask

	task automatic send_medium_end();
		send_item(REQ_MEDIUM_END, 12'($urandom), 8'($urandom));
	endtask

	task automatic send_chan_read(int unsigned n);
		repeat (n) send_item(REQ_CHAN_READ, 12'($urandom), 8'($urandom));
	endtask

	function automatic logic [11:0] any_unit();
		return 12'($urandom_range(7));
	endfunction

	function automatic logic [11:0] pick_code();
		case ($urandom_range(10))
			0: return FC_SELECT;
			1: return FC_WRITE_BIN;
			2: return FC_READ_BIN;
			3: return FC_BACKSPACE;
			4: return FC_REWIND;
			5: return FC_REWIND_UNLOAD;
			6: return FC_STATUS;
			7: return FC_WRITE_BCD;
			8: return FC_READ_BCD;
			9: return FC_FILE_MARK;
			default: return 12'($urandom);
		endcase
	endfunction

	// a request that lands in the middle of a record
	task automatic disturb_item();
		case ($urandom_range(4))
			0: send_chan_read(1);
			1: send_func(FC_SELECT | any_unit());
			2: send_func(FC_STATUS | any_unit());
			3: send_func(FC_REWIND | any_unit());
			default: send_func(FC_READ_BIN | any_unit());
		endcase
	endtask

	// one tape frame: length, data, trailer, possibly broken
	task automatic send_record(bit [31:0] len, flaw_t flaw);
		int unsigned cut;
		bit [31:0] trl;
		cut = (flaw == FLAW_END_DATA || flaw == FLAW_DISTURB) ?
			$urandom_range(len - 1) : $urandom_range(3);
		for (int i = 0; i < 4; i++) begin
			if (flaw == FLAW_END_HEADER && i == cut) begin
				send_medium_end();
				return;
			end
			send_byte(len[8 * i +: 8]);
		end
		if (len == 0 || len > MAX_REC_BYTES) return;
		for (int unsigned i = 0; i < len; i++) begin
			if (flaw == FLAW_END_DATA && i == cut) begin
				send_medium_end();
				return;
			end
			if (flaw == FLAW_DISTURB && i == cut) disturb_item();
			send_byte(8'($urandom));
		end
		trl = (flaw == FLAW_TRAILER) ? (len ^ (32'd1 << $urandom_range(31))) : len;
		for (int i = 0; i < 4; i++) begin
			if (flaw == FLAW_END_TRAILER && i == cut) begin
				send_medium_end();
				return;
			end
			send_byte(trl[8 * i +: 8]);
		end
	endtask

	// stop offering and wait for every predicted item to come out
	task automatic drain();
		in_ch.valid = 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly record reads with random content, some broken frames and noise
	task automatic random_traffic(int unsigned target);
		int unsigned start;
		int unsigned pick;
		int unsigned cap;
		bit [31:0]   len;
		flaw_t       flaw;
		start = n_effective;
		while (n_effective - start < target) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if (sb.left != 0 && $urandom_range(3) != 0) begin
					// read binary while words remain keeps the buffer
					if ($urandom_range(7) == 0) send_func(FC_READ_BIN | any_unit());
					cap = (sb.left + 1 > 12) ? 12 : sb.left + 1;
					send_chan_read($urandom_range(1, cap));
				end else begin
					if ($urandom_range(3) == 0) send_func(FC_SELECT | any_unit());
					send_func(FC_READ_BIN | any_unit());
					if (sb.phase == PH_HEADER) begin
						pick = $urandom_range(99);
						if (pick < 8)
							len = 0;
						else if (pick < 84)
							len = $urandom_range(1, 40);
						else if (pick < 95)
							len = $urandom_range(41, 400);
						else if (pick < 97)
							len = MAX_REC_BYTES + 1;
						else begin
							len = $urandom;
							if (len <= MAX_REC_BYTES) len = len + MAX_REC_BYTES + 1;
						end
						flaw = ($urandom_range(3) == 0) ?
							flaw_t'($urandom_range(1, 5)) : FLAW_NONE;
						send_record(len, flaw);
					end
					send_chan_read($urandom_range(0, sb.left + 2));
				end
			end else if (pick < 80) begin
				send_func(FC_STATUS | any_unit());
				send_chan_read($urandom_range(1, 3));
			end else begin
				send_item(req_t'($urandom_range(3)),
					($urandom_range(1) != 0) ? (pick_code() | any_unit()) : 12'($urandom),
					8'($urandom));
			end
		end
	endtask

	int unsigned tx_mix [4] = '{0, 73, 0, 35};
	int unsigned rx_mix [4] = '{0, 0, 73, 35};

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.req_type = REQ_FUNC;
		in_ch.func_code = 12'h000;
		in_ch.medium_byte = 8'h00;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: idle requests, every function code, field extremes
		send_chan_read(1);
		send_byte(8'hff);
		send_medium_end();
		send_func(12'h000);
		send_func(12'hfff);
		send_func(FC_SELECT | 12'd7);
		send_func(FC_STATUS);
		send_chan_read(1);
		send_func(FC_WRITE_BIN);
		send_func(FC_BACKSPACE);
		send_func(FC_REWIND_UNLOAD);
		send_func(FC_WRITE_BCD);
		send_func(FC_READ_BCD);
		send_func(FC_FILE_MARK);
		send_func(FC_REWIND);
		// tape mark, then a deactivation
		send_func(FC_READ_BIN);
		send_record(0, FLAW_NONE);
		send_chan_read(1);
		// medium end inside the header gives end of tape
		send_func(FC_READ_BIN | 12'd2);
		send_byte(8'h00);
		send_medium_end();
		send_func(FC_STATUS);
		send_chan_read(1);
		drain();

		// length one past the limit, then a longer record with a short last group
		send_func(FC_READ_BIN);
		send_record(MAX_REC_BYTES + 1, FLAW_NONE);
		send_func(FC_STATUS);
		send_chan_read(1);
		send_func(FC_READ_BIN);
		send_record(LONG_REC, FLAW_NONE);
		send_chan_read(sb.left + 1);
		drain();

		// random traffic under each idling mix
		for (int p = 0; p < 4; p++) begin
			tx_idle_pct = tx_mix[p];
			rx_stall_pct = rx_mix[p];
			random_traffic(PHASE_ITEMS);
			if (p == 0) begin
				// receiver holds off while replies keep coming in
				rx_hold_req = 1'b1;
				repeat (40) send_func(pick_code() | any_unit());
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d requests, %0d records parsed in full, %0d results checked",
			n_effective, sb.n_records, sb.n_checked);
		if (sb.errors == 0)
			$display("tape_record_reader_controller: match");
		else
			$display("tape_record_reader_controller: mismatch");
		$finish;
	end

endmodule
